// ----- hdl/iq_correlation_accumulator_macros.svh -----
// Assertion macros used by the correlator checker file.
`ifndef IQ_CORRELATION_ACCUMULATOR_MACROS_SVH
`define IQ_CORRELATION_ACCUMULATOR_MACROS_SVH

// Property checked at every clock edge, switched off while reset is high.
`define IQCA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define IQCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/iqca_pkg.sv -----
// Shared constants, types and helper functions of the IQ correlation accumulator.
`timescale 1ns / 1ps
`default_nettype none

package iqca_pkg;

   localparam int TABLE_DEPTH  = 48;
   localparam int ACC_WIDTH    = 48;
   localparam int POS_WIDTH    = $clog2(TABLE_DEPTH);
   localparam int INDEX_WIDTH  = 6;
   localparam int SAMPLE_WIDTH = 16;
   localparam int PROD_WIDTH   = 2 * SAMPLE_WIDTH;
   localparam int PROD_SHIFT   = 4;
   localparam int OUT_WIDTH    = 48;

   // Item kinds carried in req_type
   typedef enum logic [1:0] {
      REQ_SAMPLE      = 2'd0,
      REQ_CLEAR       = 2'd1,
      REQ_READ        = 2'd2,
      REQ_TABLE_WRITE = 2'd3
   } req_kind_type;

   // One sine/cosine table entry
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sine;
      logic signed [SAMPLE_WIDTH-1:0] cosine;
   } table_entry_type;

   // Commands from the pipeline to the table memory
   typedef struct packed {
      logic                   rd_en;
      logic                   wr_en;
      logic                   block_end;
      logic [INDEX_WIDTH-1:0] wr_index;
      table_entry_type        wr_data;
   } table_cmd_type;

   // Product scaled by an arithmetic shift (floor) and widened to the accumulator
   function automatic logic signed [ACC_WIDTH-1:0] scale_product(
      input logic signed [PROD_WIDTH-1:0] prod);
      logic signed [PROD_WIDTH-1:0] shifted;
      shifted = prod >>> PROD_SHIFT;
      return ACC_WIDTH'(shifted);
   endfunction

   // Accumulator sign-extended, then cut to the result width
   function automatic logic signed [OUT_WIDTH-1:0] acc_to_out(
      input logic signed [ACC_WIDTH-1:0] acc);
      logic signed [63:0] wide;
      wide = 64'(acc);
      return wide[OUT_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- hdl/iqca_if.sv -----
// Request and response channel interfaces of the IQ correlation accumulator.
`timescale 1ns / 1ps
`default_nettype none

interface iqca_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic signed [15:0] ref_sample;
   logic signed [15:0] meas_sample;
   logic        block_end;
   logic [5:0]  entry_index;
   logic signed [15:0] sine_value;
   logic signed [15:0] cosine_value;

   modport source (output valid, req_type, ref_sample, meas_sample, block_end,
                   entry_index, sine_value, cosine_value, input ready);
   modport sink   (input valid, req_type, ref_sample, meas_sample, block_end,
                   entry_index, sine_value, cosine_value, output ready);
endinterface

interface iqca_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [47:0] meas_sin_sum;
   logic signed [47:0] meas_cos_sum;
   logic signed [47:0] ref_sin_sum;
   logic signed [47:0] ref_cos_sum;

   modport source (output valid, meas_sin_sum, meas_cos_sum, ref_sin_sum, ref_cos_sum,
                   input ready);
   modport sink   (input valid, meas_sin_sum, meas_cos_sum, ref_sin_sum, ref_cos_sum,
                   output ready);
endinterface

`default_nettype wire

// ----- hdl/iq_correlation_accumulator.sv -----
// Top level of the IQ correlation accumulator: table read, multiply, accumulate, result.
//
// Usage:
//   req_ch carries one beat per item: a sample pair, a clear, a read or a
//   table entry write, chosen by req_type. rsp_ch carries one beat with the
//   four 48-bit sums for every read item and nothing for the other kinds.
//   Throughput is one item per cycle while req_ch.ready is high; every kind
//   may follow any other. A read result passes through the stage 1, stage 2
//   and output registers to rsp_ch; it reflects every item accepted before.
//   The pipeline is table read (registered memory read), four 16x16
//   multiplies, then the accumulate/result stage feeding the output register.
//   A stalled result holds in the output register; items keep entering until
//   a read reaches the accumulate stage with that register still full and
//   stage 1 is full; req_ch.ready then drops until the response beat is taken.
//   Synchronous reset clears the accumulators, the table position and the
//   pipeline; table entries stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module iq_correlation_accumulator (
   input wire logic  clock,
   input wire logic  reset,
   iqca_req_if.sink  req_ch,
   iqca_rsp_if.source rsp_ch
);

   localparam int AW = iqca_pkg::ACC_WIDTH;
   localparam int PW = iqca_pkg::PROD_WIDTH;
   localparam int SW = iqca_pkg::SAMPLE_WIDTH;
   localparam int OW = iqca_pkg::OUT_WIDTH;

   iqca_pkg::req_kind_type      req_kind;
   iqca_pkg::table_cmd_type     tbl_cmd;
   iqca_pkg::table_entry_type   tbl_rd;
   logic                        accept;

   // stage 1: table read in flight
   logic                        s1_valid_ff;
   iqca_pkg::req_kind_type      s1_kind_ff;
   logic signed [SW-1:0]        s1_ref_ff;
   logic signed [SW-1:0]        s1_meas_ff;

   // stage 2: products
   logic                        s2_valid_ff;
   iqca_pkg::req_kind_type      s2_kind_ff;
   logic signed [PW-1:0]        s2_ms_ff;
   logic signed [PW-1:0]        s2_mc_ff;
   logic signed [PW-1:0]        s2_rs_ff;
   logic signed [PW-1:0]        s2_rc_ff;

   // accumulators
   logic signed [AW-1:0]        acc_ms_ff;
   logic signed [AW-1:0]        acc_mc_ff;
   logic signed [AW-1:0]        acc_rs_ff;
   logic signed [AW-1:0]        acc_rc_ff;

   // output register
   logic                        out_valid_ff;
   logic signed [OW-1:0]        out_ms_ff;
   logic signed [OW-1:0]        out_mc_ff;
   logic signed [OW-1:0]        out_rs_ff;
   logic signed [OW-1:0]        out_rc_ff;

   logic                        out_free;
   logic                        s2_adv;
   logic                        s2_go;
   logic                        s1_go;

   // flow control: stall only for a read facing a full output register
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign s2_adv   = s2_valid_ff && ((s2_kind_ff != iqca_pkg::REQ_READ) || out_free);
   assign s2_go    = !s2_valid_ff || s2_adv;
   assign s1_go    = !s1_valid_ff || s2_go;

   assign req_ch.ready = s1_go;
   assign accept       = req_ch.valid && s1_go;
   assign req_kind     = iqca_pkg::req_kind_type'(req_ch.req_type);

   // table commands
   always_comb begin
      tbl_cmd                = '0;
      tbl_cmd.rd_en          = accept && (req_kind == iqca_pkg::REQ_SAMPLE);
      tbl_cmd.wr_en          = accept && (req_kind == iqca_pkg::REQ_TABLE_WRITE);
      tbl_cmd.block_end      = req_ch.block_end;
      tbl_cmd.wr_index       = req_ch.entry_index;
      tbl_cmd.wr_data.sine   = req_ch.sine_value;
      tbl_cmd.wr_data.cosine = req_ch.cosine_value;
   end

   iqca_table u_table (
      .clock   (clock),
      .reset   (reset),
      .cmd     (tbl_cmd),
      .rd_data (tbl_rd)
   );

   // stage 1 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_go) begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_kind_ff <= req_kind;
         s1_ref_ff  <= req_ch.ref_sample;
         s1_meas_ff <= req_ch.meas_sample;
      end
   end

   // stage 2: four multiplies
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_go) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_go) begin
         s2_kind_ff <= s1_kind_ff;
         s2_ms_ff   <= PW'(s1_meas_ff * tbl_rd.sine);
         s2_mc_ff   <= PW'(s1_meas_ff * tbl_rd.cosine);
         s2_rs_ff   <= PW'(s1_ref_ff * tbl_rd.sine);
         s2_rc_ff   <= PW'(s1_ref_ff * tbl_rd.cosine);
      end
   end

   // accumulate, clear
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ms_ff <= '0;
         acc_mc_ff <= '0;
         acc_rs_ff <= '0;
         acc_rc_ff <= '0;
      end else if (s2_adv) begin
         case (s2_kind_ff)
            iqca_pkg::REQ_SAMPLE: begin
               acc_ms_ff <= acc_ms_ff + iqca_pkg::scale_product(s2_ms_ff);
               acc_mc_ff <= acc_mc_ff + iqca_pkg::scale_product(s2_mc_ff);
               acc_rs_ff <= acc_rs_ff + iqca_pkg::scale_product(s2_rs_ff);
               acc_rc_ff <= acc_rc_ff + iqca_pkg::scale_product(s2_rc_ff);
            end
            iqca_pkg::REQ_CLEAR: begin
               acc_ms_ff <= '0;
               acc_mc_ff <= '0;
               acc_rs_ff <= '0;
               acc_rc_ff <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   // output register: loaded by a read, freed when the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s2_adv && (s2_kind_ff == iqca_pkg::REQ_READ)) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (s2_adv && (s2_kind_ff == iqca_pkg::REQ_READ)) begin
         out_ms_ff <= iqca_pkg::acc_to_out(acc_ms_ff);
         out_mc_ff <= iqca_pkg::acc_to_out(acc_mc_ff);
         out_rs_ff <= iqca_pkg::acc_to_out(acc_rs_ff);
         out_rc_ff <= iqca_pkg::acc_to_out(acc_rc_ff);
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.meas_sin_sum = out_ms_ff;
   assign rsp_ch.meas_cos_sum = out_mc_ff;
   assign rsp_ch.ref_sin_sum  = out_rs_ff;
   assign rsp_ch.ref_cos_sum  = out_rc_ff;

endmodule

`default_nettype wire

// ----- hdl/iqca_table.sv -----
// Sine/cosine table memory with the table position counter and registered read.
`timescale 1ns / 1ps
`default_nettype none

module iqca_table (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire iqca_pkg::table_cmd_type  cmd,
   output iqca_pkg::table_entry_type     rd_data
);

   iqca_pkg::table_entry_type         tbl_mem [iqca_pkg::TABLE_DEPTH];
   iqca_pkg::table_entry_type         rd_ff;
   logic [iqca_pkg::POS_WIDTH-1:0]    pos_ff;
   logic [iqca_pkg::POS_WIDTH-1:0]    pos_in;
   logic                              wr_ok;

   // table write ignored past the last entry
   assign wr_ok = cmd.wr_en && (32'(cmd.wr_index) < iqca_pkg::TABLE_DEPTH);

   // position advances per sample, back to zero at block end or past the last entry
   always_comb begin
      pos_in = pos_ff;
      if (cmd.rd_en) begin
         if (cmd.block_end || pos_ff == iqca_pkg::POS_WIDTH'(iqca_pkg::TABLE_DEPTH - 1)) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // single-port memory: a write or a read per beat, read data registered
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         tbl_mem[iqca_pkg::POS_WIDTH'(cmd.wr_index)] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= tbl_mem[pos_ff];
      end
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

// ----- hdl/iqca_checker.sv -----
// Port-level checker of the IQ correlation accumulator and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "iq_correlation_accumulator_macros.svh"

module iqca_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_type,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [47:0] meas_sin_sum,
   input wire logic [47:0] ref_cos_sum
);

   logic read_beat;

   assign read_beat = req_valid && req_ready && (req_type == iqca_pkg::REQ_READ);

   // a result beat held by the receiver keeps its meas_sin and ref_cos sums
   `IQCA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(meas_sin_sum) && $stable(ref_cos_sum), "rsp beat changed while stalled")

   // reset leaves no result pending
   `IQCA_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp valid after reset")

   // only a full output register can hold back requests
   `IQCA_ASSERT(a_ready_free, clock, reset, !rsp_valid |-> req_ready, "req stalled with empty rsp side")

   // a read with the receiver ready throughout must return its result
   `IQCA_ASSERT(a_read_latency, clock, reset, read_beat && rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid, "read result late")

endmodule

bind iq_correlation_accumulator iqca_checker u_iqca_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_type     (req_ch.req_type),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .meas_sin_sum (rsp_ch.meas_sin_sum),
   .ref_cos_sum  (rsp_ch.ref_cos_sum)
);

`default_nettype wire
